// ===== rtl/ged_pkg.sv =====
// ----------------------------------------------------------------------------
// ged_pkg
// Shared types and constants for the encoder and button gesture decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ged_pkg;

  // Event codes reported on event_res
  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_UP     = 3'd1,
    EV_DOWN   = 3'd2,
    EV_EXIT   = 3'd3,
    EV_BACK   = 3'd4,
    EV_DOUBLE = 3'd5,
    EV_SELECT = 3'd6
  } ev_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_DEBOUNCE   = 3'd0,
    CFG_FAST_TURN  = 3'd1,
    CFG_PITCH_FAST = 3'd2,
    CFG_LONG_PRESS = 3'd3,
    CFG_VLONG      = 3'd4,
    CFG_DBL_CLICK  = 3'd5,
    CFG_PITCH_EN   = 3'd6
  } cfg_idx_e;

  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 16;
  localparam int unsigned StepBits    = 10;  // scaled step, fits +/-64 * 5

  localparam logic [15:0] DebounceRst  = 16'd20;
  localparam logic [15:0] FastTurnRst  = 16'd50;
  localparam logic [15:0] PitchFastRst = 16'd30;
  localparam logic [15:0] LongRst      = 16'd3000;
  localparam logic [15:0] VlongRst     = 16'd5000;
  localparam logic [15:0] DblClickRst  = 16'd400;

  localparam logic [7:0] SpeedMax    = 8'd255;
  localparam logic [7:0] SpeedX5Thr  = 8'd5;
  localparam logic [7:0] SpeedX2Thr  = 8'd2;
  localparam logic [2:0] ClicksMax   = 3'd7;
  localparam logic [2:0] ClicksDbl   = 3'd2;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] fast_turn_ms;
    logic [15:0] pitch_fast_ms;
    logic [15:0] long_press_ms;
    logic [15:0] very_long_press_ms;
    logic [15:0] double_click_ms;
    logic        pitch_enable;
  } cfg_t;

  // Rotation seen on the main encoder in this transaction
  typedef struct packed {
    logic vld;
    logic up;
  } rot_t;

  // Gesture produced by the button path in this transaction
  typedef struct packed {
    logic vld;
    ev_e  code;
  } btn_ev_t;

  // Fast-step counter: bumps (saturating) on a close step, clears otherwise
  function automatic logic [7:0] speed_next(input logic hit, input logic [7:0] cnt);
    logic [7:0] res;
    if (!hit) begin
      res = 8'd0;
    end else if (cnt == SpeedMax) begin
      res = SpeedMax;
    end else begin
      res = cnt + 8'd1;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ged_enc.sv =====
// ----------------------------------------------------------------------------
// ged_enc
// Main and pitch encoder step acceleration and saturating totals.
// ----------------------------------------------------------------------------
`default_nettype none

module ged_enc #(
  parameter int unsigned TIME_BITS  = 32,
  parameter int unsigned TOTAL_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         step_i,
  input  wire ged_pkg::cfg_t                cfg_i,
  input  wire logic [TIME_BITS-1:0]         now_i,
  input  wire logic signed [6:0]            delta_i,
  input  wire logic                         pclk_i,
  input  wire logic                         pdt_i,
  input  wire logic                         consume_i,
  output ged_pkg::rot_t                     rot_o,
  output logic signed [TOTAL_BITS-1:0]      main_total_o,
  output logic signed [TOTAL_BITS-1:0]      pitch_total_o
);
  import ged_pkg::*;

  localparam int unsigned SW = ((TOTAL_BITS > StepBits) ? TOTAL_BITS : StepBits) + 1;

  function automatic logic signed [TOTAL_BITS-1:0] sat_add(
    input logic signed [TOTAL_BITS-1:0] a,
    input logic signed [StepBits-1:0]   b
  );
    logic signed [SW-1:0] s;
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    hi = {{(SW-TOTAL_BITS+1){1'b0}}, {(TOTAL_BITS-1){1'b1}}};
    lo = ~hi;
    s  = {{(SW-TOTAL_BITS){a[TOTAL_BITS-1]}}, a} + {{(SW-StepBits){b[StepBits-1]}}, b};
    if (s > hi) begin
      s = hi;
    end else if (s < lo) begin
      s = lo;
    end
    return s[TOTAL_BITS-1:0];
  endfunction

  logic [TIME_BITS-1:0]         last_turn_q, last_turn_d;
  logic [7:0]                   turn_cnt_q, turn_cnt_d;
  logic signed [TOTAL_BITS-1:0] main_sum_q, main_new;
  logic                         pclk_prev_q, pclk_prev_d;
  logic [TIME_BITS-1:0]         last_pstep_q, last_pstep_d;
  logic [7:0]                   pitch_cnt_q, pitch_cnt_d;
  logic signed [TOTAL_BITS-1:0] pitch_sum_q, pitch_new;

  logic [TIME_BITS-1:0]         turn_gap, pitch_gap;
  logic signed [StepBits-1:0]   d10, d_scaled, p_step;
  logic                         turn_hit, pitch_hit, p_move;

  // Main encoder
  always_comb begin
    d10        = {{(StepBits-7){delta_i[6]}}, delta_i};
    turn_gap   = now_i - last_turn_q;
    turn_hit   = turn_gap < TIME_BITS'(cfg_i.fast_turn_ms);
    turn_cnt_d = turn_cnt_q;
    last_turn_d = last_turn_q;
    d_scaled   = d10;
    main_new   = main_sum_q;
    if (delta_i != 7'sd0) begin
      turn_cnt_d  = speed_next(turn_hit, turn_cnt_q);
      last_turn_d = now_i;
      if (turn_cnt_d > SpeedX5Thr) begin
        d_scaled = (d10 <<< 2) + d10;
      end else if (turn_cnt_d > SpeedX2Thr) begin
        d_scaled = d10 <<< 1;
      end
      main_new = sat_add(main_sum_q, d_scaled);
    end
  end

  // Pitch encoder: a clock edge is one step, direction from the data line
  always_comb begin
    pitch_gap    = now_i - last_pstep_q;
    pitch_hit    = pitch_gap < TIME_BITS'(cfg_i.pitch_fast_ms);
    p_move       = cfg_i.pitch_enable && (pclk_i != pclk_prev_q);
    pclk_prev_d  = cfg_i.pitch_enable ? pclk_i : pclk_prev_q;
    pitch_cnt_d  = pitch_cnt_q;
    last_pstep_d = last_pstep_q;
    p_step       = (pdt_i != pclk_i) ? StepBits'(1) : -StepBits'(1);
    pitch_new    = pitch_sum_q;
    if (p_move) begin
      pitch_cnt_d  = speed_next(pitch_hit, pitch_cnt_q);
      last_pstep_d = now_i;
      if (pitch_cnt_d > SpeedX5Thr) begin
        p_step = p_step <<< 1;
      end
      pitch_new = sat_add(pitch_sum_q, p_step);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_turn_q  <= '0;
      turn_cnt_q   <= '0;
      main_sum_q   <= '0;
      pclk_prev_q  <= 1'b1;
      last_pstep_q <= '0;
      pitch_cnt_q  <= '0;
      pitch_sum_q  <= '0;
    end else if (step_i) begin
      last_turn_q  <= last_turn_d;
      turn_cnt_q   <= turn_cnt_d;
      main_sum_q   <= consume_i ? '0 : main_new;
      pclk_prev_q  <= pclk_prev_d;
      last_pstep_q <= last_pstep_d;
      pitch_cnt_q  <= pitch_cnt_d;
      pitch_sum_q  <= consume_i ? '0 : pitch_new;
    end
  end

  assign rot_o.vld     = delta_i != 7'sd0;
  assign rot_o.up      = !delta_i[6];
  assign main_total_o  = main_new;
  assign pitch_total_o = pitch_new;

endmodule

`default_nettype wire

// ===== rtl/ged_btn.sv =====
// ----------------------------------------------------------------------------
// ged_btn
// Button debounce and press classification: select, double click, back, exit.
// ----------------------------------------------------------------------------
`default_nettype none

module ged_btn #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire ged_pkg::cfg_t        cfg_i,
  input  wire logic [TIME_BITS-1:0] now_i,
  input  wire logic                 btn_i,
  output ged_pkg::btn_ev_t          ev_o
);
  import ged_pkg::*;

  logic                 raw_prev_q;
  logic [TIME_BITS-1:0] lct_q, lct_d;
  logic                 held_q, held_d;
  logic [TIME_BITS-1:0] press_q, press_d;
  logic                 await_q, await_d;
  logic [TIME_BITS-1:0] win_q, win_d;
  logic [2:0]           clicks_q, clicks_d;

  logic [TIME_BITS-1:0] stable_for, dur, win_age;
  logic                 settled;

  always_comb begin
    lct_d      = (btn_i != raw_prev_q) ? now_i : lct_q;
    stable_for = now_i - lct_d;
    settled    = stable_for > TIME_BITS'(cfg_i.debounce_ms);
    dur        = now_i - press_q;
    held_d     = held_q;
    press_d    = press_q;
    await_d    = await_q;
    win_d      = win_q;
    clicks_d   = clicks_q;
    ev_o.vld   = 1'b0;
    ev_o.code  = EV_NONE;

    if (settled) begin
      if (btn_i && !held_q) begin
        held_d  = 1'b1;
        press_d = now_i;
      end else if (!btn_i && held_q) begin
        held_d = 1'b0;
        if (dur > TIME_BITS'(cfg_i.very_long_press_ms)) begin
          ev_o.vld  = 1'b1;
          ev_o.code = EV_EXIT;
        end else if (dur > TIME_BITS'(cfg_i.long_press_ms)) begin
          ev_o.vld  = 1'b1;
          ev_o.code = EV_BACK;
        end else if (await_q) begin
          clicks_d = (clicks_q == ClicksMax) ? ClicksMax : clicks_q + 3'd1;
        end else begin
          await_d  = 1'b1;
          win_d    = now_i;
          clicks_d = 3'd1;
        end
      end
    end

    // window timeout wins over a release in the same transaction
    win_age = now_i - win_d;
    if (await_d && (win_age > TIME_BITS'(cfg_i.double_click_ms))) begin
      await_d   = 1'b0;
      ev_o.vld  = 1'b1;
      ev_o.code = (clicks_d == ClicksDbl) ? EV_DOUBLE : EV_SELECT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_prev_q <= 1'b0;
      lct_q      <= '0;
      held_q     <= 1'b0;
      press_q    <= '0;
      await_q    <= 1'b0;
      win_q      <= '0;
      clicks_q   <= '0;
    end else if (step_i) begin
      raw_prev_q <= btn_i;
      lct_q      <= lct_d;
      held_q     <= held_d;
      press_q    <= press_d;
      await_q    <= await_d;
      win_q      <= win_d;
      clicks_q   <= clicks_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/encoder_and_button_gesture_decoder.sv =====
// ----------------------------------------------------------------------------
// encoder_and_button_gesture_decoder
// Encoder acceleration, saturating totals and button gesture decoding.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one update tick per
//   transaction: time, main encoder delta, pitch lines, button, consume.
//   Output channel (out_valid_o/out_ready_i) returns one result per tick:
//   pending event and both totals, reported before consume clears them.
//   The tick is captured in the input register at acceptance, decoded in
//   one pass against the state registers, and the result is registered in
//   the output register, which drives out_valid_o, once the output is free.
//   Throughput is one transaction per cycle while the receiver does not
//   stall; the state update is combinational compare/add logic, so
//   consecutive ticks follow without gaps.
//   When the receiver stalls, the output register holds its result and the
//   input register still takes one more tick; after that in_ready_o drops.
//   Reset sets the config and valid registers to defaults and clears all
//   decoder state. Config writes (cfg_we_i) take effect at once; the user
//   must make them while no transaction is in flight; the block never checks.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_and_button_gesture_decoder #(
  parameter int unsigned TIME_BITS  = 32,
  parameter int unsigned TOTAL_BITS = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [ged_pkg::CfgIdxBits-1:0]       cfg_idx_i,
  input  wire logic [ged_pkg::CfgDataBits-1:0]      cfg_data_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic [TIME_BITS-1:0]                 now_ms_i,
  input  wire logic signed [6:0]                    main_delta_i,
  input  wire logic                                 pitch_clk_i,
  input  wire logic                                 pitch_dt_i,
  input  wire logic                                 button_level_i,
  input  wire logic                                 consume_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic [2:0]                                event_res_o,
  output logic signed [TOTAL_BITS-1:0]              encoder_total_o,
  output logic signed [TOTAL_BITS-1:0]              pitch_total_o
);
  import ged_pkg::*;

  cfg_t cfg_q;

  // input register
  logic                 s1_vld_q;
  logic [TIME_BITS-1:0] s1_now_q;
  logic signed [6:0]    s1_delta_q;
  logic                 s1_pclk_q, s1_pdt_q, s1_btn_q, s1_consume_q;

  // output register
  logic                         out_vld_q;
  ev_e                          ev_res_q;
  logic signed [TOTAL_BITS-1:0] enc_tot_q, pitch_tot_q;

  logic                         advance;
  rot_t                         rot;
  btn_ev_t                      btn_ev;
  logic signed [TOTAL_BITS-1:0] main_total, pitch_total;
  ev_e                          pending_q, pending_d;

  assign advance    = s1_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !s1_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms        <= DebounceRst;
      cfg_q.fast_turn_ms       <= FastTurnRst;
      cfg_q.pitch_fast_ms      <= PitchFastRst;
      cfg_q.long_press_ms      <= LongRst;
      cfg_q.very_long_press_ms <= VlongRst;
      cfg_q.double_click_ms    <= DblClickRst;
      cfg_q.pitch_enable       <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DEBOUNCE:   cfg_q.debounce_ms        <= cfg_data_i;
        CFG_FAST_TURN:  cfg_q.fast_turn_ms       <= cfg_data_i;
        CFG_PITCH_FAST: cfg_q.pitch_fast_ms      <= cfg_data_i;
        CFG_LONG_PRESS: cfg_q.long_press_ms      <= cfg_data_i;
        CFG_VLONG:      cfg_q.very_long_press_ms <= cfg_data_i;
        CFG_DBL_CLICK:  cfg_q.double_click_ms    <= cfg_data_i;
        CFG_PITCH_EN:   cfg_q.pitch_enable       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_now_q     <= now_ms_i;
      s1_delta_q   <= main_delta_i;
      s1_pclk_q    <= pitch_clk_i;
      s1_pdt_q     <= pitch_dt_i;
      s1_btn_q     <= button_level_i;
      s1_consume_q <= consume_i;
    end
  end

  ged_enc #(
    .TIME_BITS  (TIME_BITS),
    .TOTAL_BITS (TOTAL_BITS)
  ) u_enc (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .cfg_i         (cfg_q),
    .now_i         (s1_now_q),
    .delta_i       (s1_delta_q),
    .pclk_i        (s1_pclk_q),
    .pdt_i         (s1_pdt_q),
    .consume_i     (s1_consume_q),
    .rot_o         (rot),
    .main_total_o  (main_total),
    .pitch_total_o (pitch_total)
  );

  ged_btn #(
    .TIME_BITS (TIME_BITS)
  ) u_btn (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .cfg_i  (cfg_q),
    .now_i  (s1_now_q),
    .btn_i  (s1_btn_q),
    .ev_o   (btn_ev)
  );

  // rotation first, button gestures overwrite it
  always_comb begin
    pending_d = pending_q;
    if (btn_ev.vld) begin
      pending_d = btn_ev.code;
    end else if (rot.vld) begin
      pending_d = rot.up ? EV_UP : EV_DOWN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= EV_NONE;
      out_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        pending_q <= s1_consume_q ? EV_NONE : pending_d;
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ev_res_q    <= pending_d;
      enc_tot_q   <= main_total;
      pitch_tot_q <= pitch_total;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign event_res_o     = ev_res_q;
  assign encoder_total_o = enc_tot_q;
  assign pitch_total_o   = pitch_tot_q;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_vld_q && out_vld_q && !out_ready_i))
    else $error("input stalled without a blocked result");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("processed transaction produced no result");

  a_consume_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_consume_q) |=> (pending_q == EV_NONE))
    else $error("consume did not clear the pending event");

  a_rotation_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && rot.vld && !btn_ev.vld) |=>
      (ev_res_q == ($past(rot.up) ? EV_UP : EV_DOWN)))
    else $error("rotation event not reported");

endmodule

`default_nettype wire
